// File: src/vat_pkg.sv
// Shared constants, types and the quarter-wave sine table of the affine transform unit.
`timescale 1ns / 1ps

package vat_pkg;

    localparam int DATA_W     = 32;
    localparam int OP_W       = 3;
    localparam int ANGLE_W    = 10;
    localparam int FRAC_BITS  = 16;
    localparam int ANGLE_BITS = 10;

    // Table covers angles 0 to a quarter turn inclusive.
    localparam int QUARTER = 1 << (ANGLE_BITS - 2);
    localparam int IDX_W   = ANGLE_BITS - 1;
    localparam int COEF_W  = FRAC_BITS + 2;

    localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(64'd1 << FRAC_BITS);
    localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;

    localparam logic [63:0] PI_Q30    = 64'd3373259426;
    localparam logic [63:0] ANGLE_DEN = 64'(2 * QUARTER);
    localparam logic [63:0] ROUND_ADD = 64'd1 << (29 - FRAC_BITS);
    localparam int          SINE_TERMS = 24;
    localparam logic [63:0] SINE_DIV [SINE_TERMS] = '{
        64'd6,    64'd20,   64'd42,   64'd72,   64'd110,  64'd156,
        64'd210,  64'd272,  64'd342,  64'd420,  64'd506,  64'd600,
        64'd702,  64'd812,  64'd930,  64'd1056, 64'd1190, 64'd1332,
        64'd1482, 64'd1640, 64'd1806, 64'd1980, 64'd2162, 64'd2352
    };

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 3'd0,
        OP_TRANS3 = 3'd1,
        OP_TRANS2 = 3'd2,
        OP_SCALE3 = 3'd3,
        OP_SCALE2 = 3'd4,
        OP_ROTATE = 3'd5
    } op_t;

    typedef logic [FRAC_BITS:0] sine_entry_t;
    typedef sine_entry_t sine_tbl_t [QUARTER+1];

    typedef struct packed {
        op_t                       op;
        logic signed [DATA_W-1:0]  a;
        logic signed [DATA_W-1:0]  b;
        logic signed [DATA_W-1:0]  c;
        logic signed [DATA_W-1:0]  d;
        logic signed [COEF_W-1:0]  sin_v;
        logic signed [COEF_W-1:0]  cos_v;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

    // Taylor series of the sine in Q2.30, evaluated at elaboration only.
    function automatic sine_tbl_t build_sine_table();
        sine_tbl_t   tbl;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] sum;
        logic        sub;
        for (int k = 0; k <= QUARTER; k++) begin
            if (k == 0) begin
                tbl[k] = '0;
            end
            else if (k == QUARTER) begin
                tbl[k] = sine_entry_t'(64'd1 << FRAC_BITS);
            end
            else begin
                t    = (64'(k) * PI_Q30 + 64'(QUARTER)) / ANGLE_DEN;
                t2   = (t * t) >> 30;
                term = t;
                sum  = t;
                sub  = 1'b1;
                for (int i = 0; i < SINE_TERMS; i++) begin
                    if (term != 64'd0) begin
                        term = ((term * t2) >> 30) / SINE_DIV[i];
                        if (sub)
                        begin
                            sum = sum - term;
                        end
                        else
                        begin
                            sum = sum + term;
                        end
                        sub = !sub;
                    end
                end
                tbl[k] = sine_entry_t'((sum + ROUND_ADD) >> (30 - FRAC_BITS));
            end
        end
        return tbl;
    endfunction

    localparam sine_tbl_t SINE_TBL = build_sine_table();

endpackage

// File: src/vat_if.sv
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps

interface vat_item_if;
    import vat_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic signed [DATA_W-1:0]  a;
    logic signed [DATA_W-1:0]  b;
    logic signed [DATA_W-1:0]  c;
    logic signed [DATA_W-1:0]  d;
    logic [ANGLE_W-1:0]        angle;

    modport source (output valid, op, a, b, c, d, angle, input ready);
    modport sink   (input valid, op, a, b, c, d, angle, output ready);
endinterface

interface vat_result_if;
    import vat_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  out_x;
    logic signed [DATA_W-1:0]  out_y;
    logic signed [DATA_W-1:0]  out_z;
    logic signed [DATA_W-1:0]  out_w;

    modport source (output valid, out_x, out_y, out_z, out_w, input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

// File: src/vat_front.sv
// Input register stage with sine and cosine lookup for the rotation angle.
`timescale 1ns / 1ps

module vat_front (
    input  logic              clk,
    input  logic              rst_n,
    vat_item_if.sink          item,
    input  logic              advance,
    output vat_pkg::stage_t   stage
);
    import vat_pkg::*;

    logic                      valid_reg;
    logic                      valid_next;
    item_t                     item_reg;
    item_t                     item_next;
    logic                      take;
    logic [1:0]                quad;
    logic [IDX_W-1:0]          lo_idx;
    logic [IDX_W-1:0]          hi_idx;
    logic signed [COEF_W-1:0]  lo;
    logic signed [COEF_W-1:0]  hi;
    logic signed [COEF_W-1:0]  sin_v;
    logic signed [COEF_W-1:0]  cos_v;

    assign item.ready = !valid_reg || advance;
    assign take       = item.valid && item.ready;

    assign quad   = item.angle[ANGLE_BITS-1 -: 2];
    assign lo_idx = {1'b0, item.angle[ANGLE_BITS-3:0]};
    assign hi_idx = IDX_W'(QUARTER) - lo_idx;
    assign lo     = {1'b0, SINE_TBL[lo_idx]};
    assign hi     = {1'b0, SINE_TBL[hi_idx]};

    always_comb
    begin
        case (quad)
            2'd0:
            begin
                sin_v = lo;
                cos_v = hi;
            end
            2'd1:
            begin
                sin_v = hi;
                cos_v = -lo;
            end
            2'd2:
            begin
                sin_v = -lo;
                cos_v = -hi;
            end
            default:
            begin
                sin_v = -hi;
                cos_v = lo;
            end
        endcase
    end

    always_comb
    begin
        item_next.op    = op_t'(item.op);
        item_next.a     = item.a;
        item_next.b     = item.b;
        item_next.c     = item.c;
        item_next.d     = item.d;
        item_next.sin_v = sin_v;
        item_next.cos_v = cos_v;
    end

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

// File: src/vat_lane.sv
// One component lane: two products summed, rounded to the fixed-point grid and saturated.
`timescale 1ns / 1ps

module vat_lane (
    input  logic signed [vat_pkg::DATA_W-1:0]  m0_a,
    input  logic signed [vat_pkg::DATA_W-1:0]  m0_b,
    input  logic signed [vat_pkg::COEF_W-1:0]  m1_a,
    input  logic signed [vat_pkg::DATA_W-1:0]  m1_b,
    output logic signed [vat_pkg::DATA_W-1:0]  res
);
    import vat_pkg::*;

    localparam int P0_W  = 2 * DATA_W;
    localparam int P1_W  = COEF_W + DATA_W;
    localparam int SUM_W = P0_W + 1;
    localparam int RND_W = SUM_W - FRAC_BITS;
    localparam logic signed [SUM_W-1:0]  HALF    = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    logic signed [P0_W-1:0]   p0;
    logic signed [P1_W-1:0]   p1;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  rnd_sum;
    logic [RND_W-1:0]         shifted;
    logic                     fits;

    assign p0 = m0_a * m0_b;
    assign p1 = m1_a * m1_b;

    assign sum = {p0[P0_W-1], p0} + {{(SUM_W-P1_W){p1[P1_W-1]}}, p1};
    assign rnd_sum = sum + HALF;

    // Dropping the fraction bits of a two's complement value is a floor.
    assign shifted = rnd_sum[SUM_W-1:FRAC_BITS];
    assign fits    = (shifted[RND_W-1:DATA_W-1] == '0) || (shifted[RND_W-1:DATA_W-1] == '1);

    always_comb
    begin
        if (fits)
        begin
            res = shifted[DATA_W-1:0];
        end
        else if (shifted[RND_W-1])
        begin
            res = SAT_MIN;
        end
        else
        begin
            res = SAT_MAX;
        end
    end

endmodule

// File: src/vat_core.sv
// Vector state, operand selection, three arithmetic lanes and the result register.
`timescale 1ns / 1ps

module vat_core (
    input  logic             clk,
    input  logic             rst_n,
    input  vat_pkg::stage_t  stage,
    output logic             advance,
    vat_result_if.source     result
);
    import vat_pkg::*;

    logic signed [DATA_W-1:0]  vec_x_reg;
    logic signed [DATA_W-1:0]  vec_y_reg;
    logic signed [DATA_W-1:0]  vec_z_reg;
    logic signed [DATA_W-1:0]  vec_w_reg;
    logic signed [DATA_W-1:0]  vec_x_next;
    logic signed [DATA_W-1:0]  vec_y_next;
    logic signed [DATA_W-1:0]  vec_z_next;
    logic signed [DATA_W-1:0]  vec_w_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;

    logic signed [DATA_W-1:0]  cos_ext;
    logic signed [DATA_W-1:0]  x0_a, x0_b, x1_b, y0_a, y0_b, y1_b, z0_b;
    logic signed [COEF_W-1:0]  x1_a, y1_a, z1_a;
    logic signed [DATA_W-1:0]  lane_x, lane_y, lane_z;
    item_t                     it;

    assign it      = stage.item;
    assign advance = stage.valid && (!out_valid_reg || result.ready);
    assign cos_ext = {{(DATA_W-COEF_W){it.cos_v[COEF_W-1]}}, it.cos_v};

    // Translation folds the x * 2^F term into the second product with a unit coefficient.
    always_comb
    begin
        x0_a = it.a;
        x0_b = vec_x_reg;
        x1_a = COEF_ZERO;
        x1_b = vec_x_reg;
        y0_a = it.b;
        y0_b = vec_y_reg;
        y1_a = COEF_ZERO;
        y1_b = vec_y_reg;
        z0_b = vec_z_reg;
        z1_a = COEF_ZERO;
        case (it.op)
            OP_TRANS3, OP_TRANS2:
            begin
                x0_b = vec_w_reg;
                x1_a = COEF_ONE;
                y0_b = vec_w_reg;
                y1_a = COEF_ONE;
                z0_b = vec_w_reg;
                z1_a = COEF_ONE;
            end
            OP_ROTATE:
            begin
                x0_a = cos_ext;
                x1_a = -it.sin_v;
                x1_b = vec_y_reg;
                y0_a = cos_ext;
                y1_a = it.sin_v;
                y1_b = vec_x_reg;
            end
            default:
            begin
            end
        endcase
    end

    vat_lane u_lane_x (
        .m0_a (x0_a),
        .m0_b (x0_b),
        .m1_a (x1_a),
        .m1_b (x1_b),
        .res  (lane_x)
    );

    vat_lane u_lane_y (
        .m0_a (y0_a),
        .m0_b (y0_b),
        .m1_a (y1_a),
        .m1_b (y1_b),
        .res  (lane_y)
    );

    vat_lane u_lane_z (
        .m0_a (it.c),
        .m0_b (z0_b),
        .m1_a (z1_a),
        .m1_b (vec_z_reg),
        .res  (lane_z)
    );

    always_comb
    begin
        vec_x_next = vec_x_reg;
        vec_y_next = vec_y_reg;
        vec_z_next = vec_z_reg;
        vec_w_next = vec_w_reg;
        case (it.op)
            OP_LOAD:
            begin
                vec_x_next = it.a;
                vec_y_next = it.b;
                vec_z_next = it.c;
                vec_w_next = it.d;
            end
            OP_TRANS3, OP_SCALE3:
            begin
                vec_x_next = lane_x;
                vec_y_next = lane_y;
                vec_z_next = lane_z;
            end
            OP_TRANS2, OP_SCALE2, OP_ROTATE:
            begin
                vec_x_next = lane_x;
                vec_y_next = lane_y;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // The result register is the vector state itself: it only moves when the slot is free or its result is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            vec_x_reg     <= '0;
            vec_y_reg     <= '0;
            vec_z_reg     <= '0;
            vec_w_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                vec_x_reg <= vec_x_next;
                vec_y_reg <= vec_y_next;
                vec_z_reg <= vec_z_next;
                vec_w_reg <= vec_w_next;
            end
        end
    end

    assign result.valid = out_valid_reg;
    assign result.out_x = vec_x_reg;
    assign result.out_y = vec_y_reg;
    assign result.out_z = vec_z_reg;
    assign result.out_w = vec_w_reg;

endmodule

// File: src/vector_affine_transform_unit.sv
// Homogeneous 4-vector affine transform unit, Q15.16 fixed point. Each transfer on the
// item channel loads the held vector or transforms it in place (translate, scale, rotate),
// and one transfer on the result channel returns the vector after that step. An item is
// held in the input register, where the rotation angle is turned into sine and cosine
// from a constant quarter-wave table, and is then applied to the vector register, which
// is the result register. One item per cycle is sustained while the result channel is
// ready. The rate is set by the loop through the vector register: two parallel multiplies,
// one add, rounding and saturation per component each cycle. The vector resets to zero.
`timescale 1ns / 1ps

module vector_affine_transform_unit (
    input  logic          clk,
    input  logic          rst_n,
    vat_item_if.sink      item,
    vat_result_if.source  result
);
    import vat_pkg::*;

    stage_t  stage;
    logic    advance;

    vat_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .advance (advance),
        .stage   (stage)
    );

    vat_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .stage   (stage),
        .advance (advance),
        .result  (result)
    );

endmodule

// File: src/vat_checker.sv
// Port-level checks of the affine transform unit and the bind that attaches them.
`timescale 1ns / 1ps

module vat_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              item_valid,
    input logic                              item_ready,
    input logic                              result_valid,
    input logic                              result_ready,
    input logic signed [vat_pkg::DATA_W-1:0] out_x,
    input logic signed [vat_pkg::DATA_W-1:0] out_y,
    input logic signed [vat_pkg::DATA_W-1:0] out_z,
    input logic signed [vat_pkg::DATA_W-1:0] out_w
);
    import vat_pkg::*;

    // A stalled result stays offered.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result valid dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable({out_x, out_y, out_z, out_w}))
        else $error("result payload changed while stalled");

    // An accepted item always leads to a result on offer behind the input and vector registers.
    a_item_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> ##1 result_valid)
        else $error("accepted item produced no result");

    // With the result register empty the input side never stalls.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("item channel stalled with empty result register");

    // The held w changes only together with a new result.
    a_w_moves_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(out_w) |-> result_valid)
        else $error("vector w changed without a result");

endmodule

bind vector_affine_transform_unit vat_checker u_vat_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .out_x        (result.out_x),
    .out_y        (result.out_y),
    .out_z        (result.out_z),
    .out_w        (result.out_w)
);
